>>> design/assert_macros.svh
// Assertion macros for the hash unit's RTL files.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MH2_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion %m failed");
`define MH2_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition %m");
`else
`define MH2_ASSERT(lbl, clk, rst_n, prop)
`define MH2_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> design/mh2_pkg.sv
// Package for the MurmurHash2 unit: constants, command type, multiply helper.
// No dependencies; used by mh2_ctrl, mh2_dp and murmur2_hash_32_unit.
`default_nettype none
package mh2_pkg;
	localparam logic [31:0] MUL_CONST   = 32'h5bd1e995;
	localparam int          MIX_SHIFT   = 24;
	localparam int          FIN_SHIFT_A = 13;
	localparam int          FIN_SHIFT_B = 15;

	localparam int          ADDR_W      = 2;
	localparam logic [ADDR_W-1:0] SEED_ADDR = 2'd0;

	localparam logic [2:0]  FULL_BYTES  = 3'd4;

	typedef enum logic [1:0] {
		NB_ZERO = 2'd0,
		NB_TAIL = 2'd1,
		NB_FULL = 2'd2
	} nb_class_t;

	typedef struct packed {
		logic load;
		logic mix;
		logic fin;
		logic emit;
	} cmd_t;

	// low 32 bits of the product only
	function automatic logic [31:0] mul_m(input logic [31:0] x);
		return x * MUL_CONST;
	endfunction
endpackage
`default_nettype wire

>>> design/murmur2_hash_32_unit.sv
// Top level of the 32-bit MurmurHash2 unit: seed register on the APB port,
// sequencer mh2_ctrl and datapath mh2_dp. Depends on mh2_pkg.
//
//  channel   dir  handshake             payload
//  in        in   in_valid / in_stall   key_word, valid_bytes, first_word, last_word, key_length
//  out       out  out_valid / out_stall hash_value
//  cfg       in   APB psel/penable      paddr, pwdata -> prdata (hash_seed at 0x0)
//
// A word that is not last passes through load with both multiplies, then mix.
// A last word passes through load, mix, finalize multiply and emit; the running
// hash recurrence through the multipliers sets this order.
// Emit waits while an earlier hash is held stalled in the output register.
// Reset clears the seed, the running hash and all control; no result is pending.
`default_nettype none
module murmur2_hash_32_unit #(
	parameter logic [31:0] MAX_KEY_BYTES = 32'd65535
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mh2_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [31:0]                key_word,
	input  wire logic [2:0]                 valid_bytes,
	input  wire logic                       first_word,
	input  wire logic                       last_word,
	input  wire logic [15:0]                key_length,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [31:0]                     hash_value
);
	logic [31:0]   seed_q;
	mh2_pkg::cmd_t cmd;

	assign pready = 1'b1;
	assign prdata = (paddr == mh2_pkg::SEED_ADDR) ? seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == mh2_pkg::SEED_ADDR)) begin
			seed_q <= pwdata;
		end
	end

	mh2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_word (last_word),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	mh2_dp #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.hash_seed   (seed_q),
		.key_word    (key_word),
		.valid_bytes (valid_bytes),
		.first_word  (first_word),
		.key_length  (key_length),
		.hash_value  (hash_value)
	);
endmodule
`default_nettype wire

>>> design/mh2_ctrl.sv
// Sequencer for the hash unit: load, mix, finalize, emit; owns the result valid.
// Depends on mh2_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mh2_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          last_word,
	input  wire logic          out_stall,
	output logic               in_stall,
	output logic               out_valid,
	output mh2_pkg::cmd_t      cmd
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MIX  = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   last_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.mix  = 1'b0;
		cmd.fin  = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MIX;
				end
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = last_q ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= last_word;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MH2_ASSERT(a_accept_to_mix, clk, arst_n, accept |=> (state_q == ST_MIX))
	`MH2_ASSERT(a_mix_not_last, clk, arst_n, (cmd.mix && !last_q) |=> (state_q == ST_IDLE))
	`MH2_ASSERT(a_fin_to_emit, clk, arst_n, cmd.fin |=> (state_q == ST_EMIT))
	`MH2_NEVER(a_no_overwrite, clk, arst_n, cmd.emit && out_valid_q && out_stall)
	`MH2_ASSERT(a_emit_valid, clk, arst_n, cmd.emit |=> out_valid_q)
endmodule
`default_nettype wire

>>> design/mh2_dp.sv
// Datapath for the hash unit: two constant multipliers, running hash, result register.
// Depends on mh2_pkg; driven by commands from mh2_ctrl.
`default_nettype none
module mh2_dp #(
	parameter logic [31:0] MAX_KEY_BYTES = 32'd65535
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mh2_pkg::cmd_t cmd,
	input  wire logic [31:0]   hash_seed,
	input  wire logic [31:0]   key_word,
	input  wire logic [2:0]    valid_bytes,
	input  wire logic          first_word,
	input  wire logic [15:0]   key_length,
	output logic [31:0]        hash_value
);
	logic [31:0]          run_q;
	logic [31:0]          h0_q;
	logic [31:0]          hm_q;
	logic [31:0]          ka_q;
	logic [31:0]          hash_q;
	mh2_pkg::nb_class_t   cls_q;

	mh2_pkg::nb_class_t   cls_d;
	logic [15:0]          len_sat;
	logic [31:0]          h0;
	logic [31:0]          tail_mask;
	logic [31:0]          mul_a_in, mul_a_out;
	logic [31:0]          mul_b_in, mul_b_out;
	logic [31:0]          ka_mix;
	logic [31:0]          run_fin;

	always_comb begin
		if ({16'b0, key_length} > MAX_KEY_BYTES) begin
			len_sat = MAX_KEY_BYTES[15:0];
		end else begin
			len_sat = key_length;
		end
		h0 = first_word ? (hash_seed ^ {16'b0, len_sat}) : run_q;

		if (valid_bytes == 3'd0) begin
			cls_d = mh2_pkg::NB_ZERO;
		end else if (valid_bytes >= mh2_pkg::FULL_BYTES) begin
			cls_d = mh2_pkg::NB_FULL;
		end else begin
			cls_d = mh2_pkg::NB_TAIL;
		end

		unique case (valid_bytes[1:0])
			2'd1:    tail_mask = 32'h0000_00ff;
			2'd2:    tail_mask = 32'h0000_ffff;
			default: tail_mask = 32'h00ff_ffff;
		endcase
	end

	assign ka_mix  = ka_q ^ (ka_q >> mh2_pkg::MIX_SHIFT);
	assign run_fin = run_q ^ (run_q >> mh2_pkg::FIN_SHIFT_A);

	// key-side multiplier: raw word on load, shifted product on mix
	assign mul_a_in  = cmd.load ? key_word : ka_mix;
	assign mul_a_out = mh2_pkg::mul_m(mul_a_in);

	// hash-side multiplier: start hash (tail folded in) on load, finalization otherwise
	always_comb begin
		if (cmd.load) begin
			mul_b_in = (cls_d == mh2_pkg::NB_TAIL) ? (h0 ^ (key_word & tail_mask)) : h0;
		end else begin
			mul_b_in = run_fin;
		end
	end
	assign mul_b_out = mh2_pkg::mul_m(mul_b_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (cmd.mix) begin
			unique case (cls_q)
				mh2_pkg::NB_FULL: run_q <= hm_q ^ mul_a_out;
				mh2_pkg::NB_TAIL: run_q <= hm_q;
				default:          run_q <= h0_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h0_q  <= h0;
			ka_q  <= mul_a_out;
			hm_q  <= mul_b_out;
			cls_q <= cls_d;
		end else if (cmd.fin) begin
			hm_q <= mul_b_out;
		end
		if (cmd.emit) begin
			hash_q <= hm_q ^ (hm_q >> mh2_pkg::FIN_SHIFT_B);
		end
	end

	assign hash_value = hash_q;
endmodule
`default_nettype wire

>>> bench/tb_murmur2_hash_32_unit.sv
// Testbench for murmur2_hash_32_unit: directed and random keys checked against
// an in-bench MurmurHash2 predictor, with random idling and output back-pressure.
// Depends on mh2_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_murmur2_hash_32_unit;
	localparam logic [31:0] HASH_MUL    = 32'h5bd1e995;
	localparam logic [31:0] LEN_CAP     = 32'd65535;
	localparam int          HOLD_CYCLES = 300;
	localparam int          DRAIN_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        first;
		logic        last;
		logic [15:0] len;
	} hash_req_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       psel        = 1'b0;
	logic                       penable     = 1'b0;
	logic                       pwrite      = 1'b0;
	logic [mh2_pkg::ADDR_W-1:0] paddr       = '0;
	logic [31:0]                pwdata      = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic [31:0]                key_word    = '0;
	logic [2:0]                 valid_bytes = '0;
	logic                       first_word  = 1'b0;
	logic                       last_word   = 1'b0;
	logic [15:0]                key_length  = '0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic [31:0]                hash_value;

	logic [31:0] seed_copy = '0;
	logic [31:0] running_copy = '0;
	logic [31:0] hash_q[$];

	int errors = 0;
	int words_sent = 0;
	int hashes_seen = 0;
	int seed_writes = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int stall_run = 0;

	murmur2_hash_32_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.key_word(key_word), .valid_bytes(valid_bytes), .first_word(first_word),
		.last_word(last_word), .key_length(key_length),
		.out_valid(out_valid), .out_stall(out_stall), .hash_value(hash_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] mix_full(input logic [31:0] h, input logic [31:0] k);
		k = k * HASH_MUL;
		k = k ^ (k >> 24);
		k = k * HASH_MUL;
		return (h * HASH_MUL) ^ k;
	endfunction

	function automatic logic [31:0] mix_tail(input logic [31:0] h, input logic [31:0] w,
			input logic [2:0] nb);
		logic [31:0] mask;
		mask = (nb == 3'd1) ? 32'h0000_00ff : (nb == 3'd2) ? 32'h0000_ffff : 32'h00ff_ffff;
		return (h ^ (w & mask)) * HASH_MUL;
	endfunction

	function automatic logic [31:0] finish_hash(input logic [31:0] h);
		h = h ^ (h >> 13);
		h = h * HASH_MUL;
		return h ^ (h >> 15);
	endfunction

	function automatic logic [31:0] step_hash(input logic [31:0] prev, input logic [31:0] seed,
			input hash_req_t r);
		logic [31:0] len32;
		logic [31:0] h;
		logic [2:0]  nb;
		len32 = {16'b0, r.len};
		if (len32 > LEN_CAP)
			len32 = LEN_CAP;
		nb = (r.nbytes > 3'd4) ? 3'd4 : r.nbytes;
		h = r.first ? (seed ^ len32) : prev;
		if (nb == 3'd4)
			h = mix_full(h, r.word);
		else if (nb != 3'd0)
			h = mix_tail(h, r.word, nb);
		return h;
	endfunction

	// output back-pressure: random stall runs, plus a long counted hold on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_run > 0) begin
			stall_run--;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 30);
			stall_run = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			hashes_seen++;
			if (hash_q.size() == 0) begin
				$error("hash_value: expected none, actual %h", hash_value);
				errors++;
			end else begin
				logic [31:0] want;
				want = hash_q.pop_front();
				if (hash_value !== want) begin
					$error("hash_value: expected %h, actual %h", want, hash_value);
					errors++;
				end
			end
		end
	end

	task automatic send_word(input hash_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		key_word    <= r.word;
		valid_bytes <= r.nbytes;
		first_word  <= r.first;
		last_word   <= r.last;
		key_length  <= r.len;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		running_copy = step_hash(running_copy, seed_copy, r);
		if (r.last)
			hash_q.push_back(finish_hash(running_copy));
		if (r.first || r.last || r.nbytes != 3'd0)
			words_sent++;
	endtask

	task automatic send_fields(input logic [31:0] w, input logic [2:0] nb, input logic f,
			input logic l, input logic [15:0] len);
		hash_req_t r;
		r = '{word: w, nbytes: nb, first: f, last: l, len: len};
		send_word(r);
	endtask

	// byte key of nbytes bytes; the length field is optionally wrong
	task automatic send_key(input int unsigned nbytes, input bit true_len);
		int unsigned nw;
		int unsigned left;
		logic [15:0] len;
		nw = (nbytes == 0) ? 1 : (nbytes + 3) / 4;
		len = true_len ? nbytes[15:0] : 16'($urandom_range(0, 65535));
		for (int unsigned i = 0; i < nw; i++) begin
			left = nbytes - 4 * i;
			send_fields($urandom, (left >= 4) ? 3'd4 : 3'(left), i == 0, i == nw - 1, len);
		end
	endtask

	task automatic drain_hashes();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (hash_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (12) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= mh2_pkg::SEED_ADDR;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		seed_copy = v;
		seed_writes++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== seed_copy) begin
			$error("prdata: expected %h, actual %h", seed_copy, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_fields(32'h0000_0000, 3'd0, 1'b1, 1'b1, 16'd0);
		send_fields(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 16'hffff);
		send_fields(32'h0000_0000, 3'd4, 1'b1, 1'b1, 16'd0);
		send_fields(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 16'd1);
		send_fields(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 16'd2);
		send_fields(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 16'd3);
		send_fields(32'ha5a5_5a5a, 3'd5, 1'b1, 1'b1, 16'd4);
		send_fields(32'h1234_5678, 3'd6, 1'b1, 1'b1, 16'd4);
		send_fields(32'h8000_0001, 3'd7, 1'b1, 1'b1, 16'd4);
		send_fields(32'h6c6c_6568, 3'd4, 1'b1, 1'b0, 16'd5);
		send_fields(32'h0000_006f, 3'd1, 1'b0, 1'b1, 16'd5);
		// zero valid bytes mid-key
		send_fields(32'hdead_beef, 3'd4, 1'b1, 1'b0, 16'd6);
		send_fields(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 16'hffff);
		send_fields(32'h0000_beef, 3'd2, 1'b0, 1'b1, 16'd6);
		// partial word before the last word
		send_fields(32'h00ab_cdef, 3'd3, 1'b1, 1'b0, 16'd7);
		send_fields(32'hcafe_f00d, 3'd4, 1'b0, 1'b1, 16'd7);
		// no first word: continues from the previous key
		send_fields(32'h0bad_c0de, 3'd4, 1'b0, 1'b1, 16'd0);
		send_fields(32'h0000_0000, 3'd0, 1'b0, 1'b1, 16'd0);
		// length field disagrees with the bytes delivered
		send_fields(32'h7fff_ffff, 3'd4, 1'b1, 1'b1, 16'h8000);
		drain_hashes();
	endtask

	task automatic test_seed_extremes();
		write_seed(32'hffff_ffff);
		send_fields(32'h0000_0000, 3'd0, 1'b1, 1'b1, 16'd0);
		send_fields(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 16'hffff);
		drain_hashes();
		write_seed(32'h8000_0000);
		send_fields(32'h0000_0000, 3'd0, 1'b1, 1'b1, 16'd0);
		send_fields(32'h5555_aaaa, 3'd3, 1'b1, 1'b1, 16'd3);
		drain_hashes();
	endtask

	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_key($urandom_range(0, 4), 1'b1);
		no_idle = 1'b0;
		drain_hashes();
	endtask

	task automatic test_random_keys(input logic [31:0] seed, input int count, input bit quiet);
		int target;
		int r;
		target = words_sent + count;
		write_seed(seed);
		no_idle = quiet;
		while (words_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				if ($urandom_range(0, 99) < 85)
					send_key($urandom_range(0, 16), $urandom_range(0, 9) != 0);
				else
					send_key($urandom_range(17, 64), $urandom_range(0, 9) != 0);
			end else begin
				send_fields($urandom, 3'($urandom_range(0, 7)), 1'($urandom),
					1'($urandom), 16'($urandom));
			end
		end
		no_idle = 1'b0;
		drain_hashes();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_seed_extremes();
		test_backpressure();
		test_random_keys($urandom, 120, 1'b0);
		test_random_keys(32'hffff_ffff, 120, 1'b0);
		test_random_keys(32'h0000_0000, 100, 1'b1);
		test_random_keys($urandom, 120, 1'b0);
		if (hash_q.size() != 0) begin
			$error("hash_value: %0d expected hashes never arrived", hash_q.size());
			errors++;
		end
		$display("Sent %0d key words under %0d seed settings, %0d hashes compared.",
			words_sent, seed_writes, hashes_seen);
		$display("Covered empty, tail, oversized and headless keys and a long output hold.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
